/* rtl/software_timer_event_table_assert.svh */
// Assertion macros used by the timer table RTL.
`ifndef SOFTWARE_TIMER_EVENT_TABLE_ASSERT_SVH
`define SOFTWARE_TIMER_EVENT_TABLE_ASSERT_SVH

// Checked on every rising clock edge while reset is released.
`define STV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define STV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* rtl/stv_pkg.sv */
package stv_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int RESULT_CAP    = 16;

    localparam logic [1:0] OP_ACTIVATE = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_SERVICE  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  event_id;
        logic [31:0] delay_ms;
        logic        restart_mode;
    } t_in;

    typedef struct packed {
        logic [3:0] slot_index;
        logic       table_full;
        logic       fired;
        logic [7:0] fired_event;
        logic       last;
    } t_out;

    typedef struct packed {
        logic        active;
        logic [31:0] remaining;
        logic [7:0]  event_id;
    } t_slot;

endpackage

/* rtl/stv_cell.sv */
module stv_cell import stv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  logic  i_tick,
    input  t_slot i_slot,
    output t_slot o_slot
);

    logic        r_active;
    logic [31:0] r_remaining;
    logic [7:0]  r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_shift) begin
            r_active <= i_slot.active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_remaining <= i_slot.remaining;
            r_event     <= i_slot.event_id;
        end else if (i_tick && r_active && (r_remaining != 32'd0)) begin
            r_remaining <= r_remaining - 32'd1;
        end
    end

    assign o_slot = '{active: r_active, remaining: r_remaining, event_id: r_event};

endmodule

/* rtl/software_timer_event_table.sv */
// Channel  | Valid       | Ready       | Payload
// input    | i_in_valid  | o_in_ready  | i_in_data  (t_in)
// output   | o_out_valid | i_out_ready | o_out_data (t_out)
//
// The slots form a ring of cells that rotates one slot per cycle past the head except
// in a stall. A tick applies when taken; an activate rotates to search, then to apply;
// a service rotates once, then flushes. A service rotation pauses at an expired slot
// while an earlier expired slot waits to be reported and the output register still holds
// an untaken transaction. Reset clears every active bit and needs no clearing pass. A
// new input transaction is taken while the last result waits in the output register.
module software_timer_event_table import stv_pkg::*; #(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    `include "software_timer_event_table_assert.svh"

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(RESULT_CAP + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SEARCH  = 3'd1;
    localparam logic [2:0] S_APPLY   = 3'd2;
    localparam logic [2:0] S_RESULT  = 3'd3;
    localparam logic [2:0] S_SERVICE = 3'd4;
    localparam logic [2:0] S_FLUSH   = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_pos, n_pos;
    logic          r_match, n_match;
    logic          r_free, n_free;
    logic [IW-1:0] r_match_idx, n_match_idx;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic [7:0]    r_ev, n_ev;
    logic [31:0]   r_delay, n_delay;
    logic          r_restart, n_restart;
    logic          r_pend_valid, n_pend_valid;
    logic [3:0]    r_pend_idx, n_pend_idx;
    logic [7:0]    r_pend_event, n_pend_event;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;
    logic          n_load;

    t_slot         w_cell_q [SLOTS];
    t_slot         w_tail;
    t_slot         w_head;
    logic          w_accept, w_tick, w_shift, w_stall, w_expire, w_out_free, w_last_pos;
    logic          w_tgt_valid;
    logic [IW-1:0] w_tgt_idx;
    logic [IW+3:0] w_pos_ext, w_tgt_ext;

    assign w_head      = w_cell_q[0];
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_tick      = w_accept && (i_in_data.op == OP_TICK);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last_pos  = (r_pos == IW'(SLOTS - 1));
    assign w_tgt_valid = r_match || r_free;
    assign w_tgt_idx   = r_match ? r_match_idx : r_free_idx;
    assign w_pos_ext   = {4'b0000, r_pos};
    assign w_tgt_ext   = {4'b0000, w_tgt_idx};
    assign w_expire    = (r_state == S_SERVICE) && w_head.active &&
                         (w_head.remaining == 32'd0) && (r_count < CW'(RESULT_CAP));
    assign w_stall     = w_expire && r_pend_valid && !w_out_free;
    assign w_shift     = (r_state == S_SEARCH) || (r_state == S_APPLY) ||
                         ((r_state == S_SERVICE) && !w_stall);

    always_comb begin
        w_tail = w_head;
        if ((r_state == S_APPLY) && w_tgt_valid && (r_pos == w_tgt_idx)) begin
            if (r_match) begin
                if (r_restart) begin
                    w_tail.remaining = r_delay;
                end
            end else begin
                w_tail = '{active: 1'b1, remaining: r_delay, event_id: r_ev};
            end
        end else if (w_expire) begin
            w_tail.active = 1'b0;
        end
    end

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        t_slot w_d;
        if (k == SLOTS - 1) begin : g_end
            assign w_d = w_tail;
        end else begin : g_mid
            assign w_d = w_cell_q[k + 1];
        end
        stv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_tick  (w_tick),
            .i_slot  (w_d),
            .o_slot  (w_cell_q[k])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_match      = r_match;
        n_free       = r_free;
        n_match_idx  = r_match_idx;
        n_free_idx   = r_free_idx;
        n_ev         = r_ev;
        n_delay      = r_delay;
        n_restart    = r_restart;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_pend_event = r_pend_event;
        n_count      = r_count;
        n_load       = 1'b0;
        n_out        = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ev         = i_in_data.event_id;
                    n_delay      = i_in_data.delay_ms;
                    n_restart    = i_in_data.restart_mode;
                    n_pos        = '0;
                    n_match      = 1'b0;
                    n_free       = 1'b0;
                    n_pend_valid = 1'b0;
                    n_count      = '0;
                    case (i_in_data.op)
                        OP_ACTIVATE: n_state = S_SEARCH;
                        OP_SERVICE:  n_state = S_SERVICE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_head.active && (w_head.event_id == r_ev) && !r_match) begin
                    n_match     = 1'b1;
                    n_match_idx = r_pos;
                end
                if (!w_head.active && !r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_pos;
                end
                n_pos = w_last_pos ? '0 : r_pos + IW'(1);
                if (w_last_pos) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_pos = w_last_pos ? '0 : r_pos + IW'(1);
                if (w_last_pos) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_load           = 1'b1;
                    n_out.slot_index = w_tgt_valid ? w_tgt_ext[3:0] : 4'd0;
                    n_out.table_full = !w_tgt_valid;
                    n_out.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SERVICE: begin
                if (!w_stall) begin
                    if (w_expire) begin
                        if (r_pend_valid) begin
                            n_load            = 1'b1;
                            n_out.slot_index  = r_pend_idx;
                            n_out.fired       = 1'b1;
                            n_out.fired_event = r_pend_event;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = w_pos_ext[3:0];
                        n_pend_event = w_head.event_id;
                        n_count      = r_count + CW'(1);
                    end
                    n_pos = w_last_pos ? '0 : r_pos + IW'(1);
                    if (w_last_pos) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_load            = 1'b1;
                    n_out.slot_index  = r_pend_idx;
                    n_out.fired       = 1'b1;
                    n_out.fired_event = r_pend_event;
                    n_out.last        = 1'b1;
                    n_pend_valid      = 1'b0;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = n_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_match      <= n_match;
        r_free       <= n_free;
        r_match_idx  <= n_match_idx;
        r_free_idx   <= n_free_idx;
        r_ev         <= n_ev;
        r_delay      <= n_delay;
        r_restart    <= n_restart;
        r_pend_idx   <= n_pend_idx;
        r_pend_event <= n_pend_event;
        r_count      <= n_count;
        if (n_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `STV_ASSERT(a_no_overwrite, n_load |-> w_out_free, "result register overwritten")
    `STV_ASSERT(a_idle_no_pending, o_in_ready |-> !r_pend_valid, "pending result left behind")
    `STV_ASSERT(a_stall_holds, w_stall |=> $stable(r_pos), "ring advanced during a stall")
    `STV_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (o_in_ready && !o_out_valid),
        "block not idle after reset")

endmodule
